FILE: src/tts_pkg.sv
`timescale 1ns / 1ps
// tts_pkg: shared types, constants and helpers of the task timer scheduler
// used by every module under src, depends on nothing
package tts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int TIME_W   = 63;
  localparam int TICK_W   = 48;
  localparam int MS_W     = 32;
  localparam int TPM_W    = 16;
  localparam int TASK_W   = 16;
  localparam int MODE_W   = 2;
  localparam int FSLOT_W  = 4;
  localparam int IN_W     = 152;
  localparam int OUT_W    = 88;

  localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_MULTI = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd2;

  typedef enum logic [1:0] {
    OP_SCHED    = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_PROCESS  = 2'd2,
    OP_COMPLETE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_OK   = 3'd0,
    KIND_MISS = 3'd1,
    KIND_DUE  = 3'd2,
    KIND_WAKE = 3'd3,
    KIND_NONE = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [TASK_W-1:0]  task_id;
    logic [MODE_W-1:0]  mode;
    logic [MS_W-1:0]    rate_ms;
    logic [TIME_W-1:0]  now;
    logic [FSLOT_W-1:0] slot;
    logic [MS_W-1:0]    delay_ms;
  } item_t;

  // classified request as it travels from front to back
  typedef struct packed {
    op_e                op;
    logic [TASK_W-1:0]  task_id;
    logic [MODE_W-1:0]  mode;
    logic [MS_W-1:0]    rate_ms;
    logic [TIME_W-1:0]  now;
    logic [FSLOT_W-1:0] slot;
    logic               task_zero;
    logic               delay_nz;
    logic               slot_bad;
    logic [TICK_W-1:0]  ticks;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    logic [FSLOT_W-1:0] slot;
    logic [TASK_W-1:0]  task_id;
    logic [TIME_W-1:0]  wake;
  } res_t;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [MODE_W-1:0] mode;
    logic [MS_W-1:0]   rate;
    logic [TIME_W-1:0] next_due;
    logic [TIME_W-1:0] start;
  } entry_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TICK_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - TICK_W){1'b0}}, b};
    return s[TIME_W] ? TMAX : s[TIME_W-1:0];
  endfunction

endpackage

FILE: src/tts_cmd_fifo.sv
`timescale 1ns / 1ps
// tts_cmd_fifo: two-entry queue of classified requests between front and back
// depends on tts_pkg
module tts_cmd_fifo import tts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/tts_front.sv
`timescale 1ns / 1ps
// tts_front: takes input items, decodes them and scales ms values to ticks
// depends on tts_pkg
module tts_front import tts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TPM_W-1:0]  tpm_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  logic  s1_vld_q, s1_vld_d;
  item_t s1_q;
  logic [MS_W-1:0] ms;

  assign in_ready_o  = !s1_vld_q || cmd_ready_i;
  assign cmd_valid_o = s1_vld_q;

  // complete uses the returned delay, everything else the rate
  assign ms = (op_e'(s1_q.opcode) == OP_COMPLETE) ? s1_q.delay_ms : s1_q.rate_ms;

  always_comb begin
    cmd_o.op        = op_e'(s1_q.opcode);
    cmd_o.task_id   = s1_q.task_id;
    cmd_o.mode      = s1_q.mode;
    cmd_o.rate_ms   = s1_q.rate_ms;
    cmd_o.now       = s1_q.now;
    cmd_o.slot      = s1_q.slot;
    cmd_o.task_zero = (s1_q.task_id == '0);
    cmd_o.delay_nz  = (s1_q.delay_ms != '0);
    cmd_o.slot_bad  = (32'(s1_q.slot) >= 32'(SLOTS));
    cmd_o.ticks     = TICK_W'(ms * tpm_i);
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_valid_i && in_ready_o) begin
      s1_vld_d = 1'b1;
    end else if (cmd_ready_i) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_item_i;
    end
  end

endmodule

FILE: src/tts_back.sv
`timescale 1ns / 1ps
// tts_back: slot table and sequencer that scans slots and produces results
// depends on tts_pkg
module tts_back import tts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TPM_W-1:0]  tpm_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_o,
  output logic              out_last_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CHK, ST_BIND, ST_MUL, ST_DIV, ST_FIX, ST_END, ST_OUT
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              hit_q, hit_d;
  logic              any_q, any_d;
  logic [TIME_W-1:0] min_q, min_d;
  logic [TICK_W-1:0] p_q, p_d;
  logic [TICK_W:0]   rem_q, rem_d;
  logic [TIME_W-1:0] div_q, div_d;
  logic [5:0]        cnt_q, cnt_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              last_q, last_d;
  logic              ovld_q, ovld_d;
  logic [SLOTS-1:0]  valid_q, valid_d;

  entry_t            mem [SLOTS];
  entry_t            rd_q;
  logic              we;
  logic [SLOT_W-1:0] wa;
  entry_t            wd;

  logic              can_emit;
  logic [SLOT_W-1:0] free_idx;
  logic              free_any;
  logic [TICK_W:0]   rem_sh;
  logic [TIME_W-1:0] t_new;
  logic [TIME_W-1:0] t_fix;
  logic [FSLOT_W-1:0] rs;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = ovld_q;
  assign out_o       = out_q;
  assign out_last_o  = last_q;
  assign can_emit    = !ovld_q || out_ready_i;
  assign rs          = FSLOT_W'(idx_q);
  assign t_new       = sat_add(cmd_q.now, cmd_q.ticks);
  assign rem_sh      = {rem_q[TICK_W-1:0], div_q[TIME_W-1]};
  assign t_fix       = sat_add(cmd_q.now - TIME_W'(rem_q), p_q);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  function automatic res_t mk(input kind_e k, input logic [FSLOT_W-1:0] s,
                              input logic [TASK_W-1:0] t,
                              input logic [TIME_W-1:0] w);
    res_t r;
    r.kind    = k;
    r.slot    = s;
    r.task_id = t;
    r.wake    = w;
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    any_d   = any_q;
    min_d   = min_q;
    p_d     = p_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    out_d   = out_q;
    last_d  = last_q;
    ovld_d  = ovld_q && !out_ready_i;
    valid_d = valid_q;
    we      = 1'b0;
    wa      = idx_q;
    wd      = rd_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          idx_d = '0;
          hit_d = 1'b0;
          any_d = 1'b0;
          min_d = TMAX;
          res_d = mk(KIND_MISS, '0, '0, '0);
          case (cmd_i.op)
            OP_SCHED: begin
              if (cmd_i.task_zero) begin
                state_d = ST_OUT;
              end else if (cmd_i.mode == MODE_MULTI) begin
                state_d = ST_BIND;
              end else begin
                state_d = ST_RD;
              end
            end
            OP_CANCEL: begin
              state_d = cmd_i.task_zero ? ST_OUT : ST_RD;
            end
            OP_PROCESS: begin
              state_d = ST_RD;
            end
            default: begin
              idx_d = SLOT_W'(cmd_i.slot);
              if (cmd_i.slot_bad || !valid_q[SLOT_W'(cmd_i.slot)]) begin
                state_d = ST_OUT;
              end else begin
                state_d = ST_RD;
              end
            end
          endcase
        end
      end

      ST_RD: begin
        state_d = ST_CHK;
      end

      ST_CHK: begin
        case (cmd_q.op)
          OP_SCHED, OP_CANCEL: begin
            if (valid_q[idx_q] && rd_q.task_id == cmd_q.task_id) begin
              if (cmd_q.op == OP_SCHED) begin
                hit_d   = 1'b1;
                state_d = ST_BIND;
              end else begin
                valid_d[idx_q] = 1'b0;
                res_d   = mk(KIND_OK, rs, cmd_q.task_id, '0);
                state_d = ST_OUT;
              end
            end else if (32'(idx_q) == SLOTS - 1) begin
              state_d = (cmd_q.op == OP_SCHED) ? ST_BIND : ST_OUT;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_RD;
            end
          end
          OP_PROCESS: begin
            logic due;
            logic adv;
            due = valid_q[idx_q] && (rd_q.next_due <= cmd_q.now);
            adv = !due || can_emit;
            if (due && can_emit) begin
              ovld_d = 1'b1;
              out_d  = mk(KIND_DUE, rs, rd_q.task_id, rd_q.next_due);
              last_d = 1'b0;
            end
            if (adv) begin
              if (valid_q[idx_q]) begin
                any_d = 1'b1;
                if (!any_q || rd_q.next_due < min_q) begin
                  min_d = rd_q.next_due;
                end
              end
              if (32'(idx_q) == SLOTS - 1) begin
                state_d = ST_END;
              end else begin
                idx_d   = idx_q + 1'b1;
                state_d = ST_RD;
              end
            end
          end
          default: begin
            if (cmd_q.delay_nz) begin
              we          = 1'b1;
              wd.next_due = t_new;
              res_d       = mk(KIND_OK, rs, rd_q.task_id, t_new);
              state_d     = ST_OUT;
            end else if (rd_q.mode == MODE_FIXED) begin
              p_d     = TICK_W'(rd_q.rate * tpm_i);
              state_d = ST_MUL;
            end else begin
              valid_d[idx_q] = 1'b0;
              res_d   = mk(KIND_OK, rs, rd_q.task_id, '0);
              state_d = ST_OUT;
            end
          end
        endcase
      end

      ST_BIND: begin
        if (hit_q || free_any) begin
          wa          = hit_q ? idx_q : free_idx;
          we          = 1'b1;
          wd.task_id  = cmd_q.task_id;
          wd.mode     = cmd_q.mode;
          wd.rate     = cmd_q.rate_ms;
          wd.next_due = t_new;
          wd.start    = t_new;
          valid_d[wa] = 1'b1;
          res_d       = mk(KIND_OK, FSLOT_W'(wa), cmd_q.task_id, t_new);
        end
        state_d = ST_OUT;
      end

      ST_MUL: begin
        logic [TIME_W-1:0] nx;
        nx = sat_add(rd_q.start, p_q);
        if (p_q == '0) begin
          valid_d[idx_q] = 1'b0;
          res_d   = mk(KIND_OK, rs, rd_q.task_id, '0);
          state_d = ST_OUT;
        end else if (nx <= cmd_q.now) begin
          // whole-period catch-up: remainder of (now - nx) by the period
          div_d   = cmd_q.now - nx;
          rem_d   = '0;
          cnt_d   = 6'(TIME_W - 1);
          state_d = ST_DIV;
        end else begin
          we          = 1'b1;
          wd.next_due = nx;
          wd.start    = nx;
          res_d       = mk(KIND_OK, rs, rd_q.task_id, nx);
          state_d     = ST_OUT;
        end
      end

      ST_DIV: begin
        div_d = {div_q[TIME_W-2:0], 1'b0};
        rem_d = (rem_sh >= {1'b0, p_q}) ? rem_sh - {1'b0, p_q} : rem_sh;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end

      ST_FIX: begin
        we          = 1'b1;
        wd.next_due = t_fix;
        wd.start    = t_fix;
        res_d       = mk(KIND_OK, rs, rd_q.task_id, t_fix);
        state_d     = ST_OUT;
      end

      ST_END: begin
        if (can_emit) begin
          ovld_d  = 1'b1;
          out_d   = any_q ? mk(KIND_WAKE, '0, '0, min_q) : mk(KIND_NONE, '0, '0, '0);
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (can_emit) begin
          ovld_d  = 1'b1;
          out_d   = res_q;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
      valid_q <= '0;
      hit_q   <= 1'b0;
      any_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      valid_q <= valid_d;
      hit_q   <= hit_d;
      any_q   <= any_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    min_q  <= min_d;
    p_q    <= p_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    res_q  <= res_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  // slot table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[idx_d];
  end

endmodule

FILE: src/task_timer_scheduler.sv
`timescale 1ns / 1ps
// task_timer_scheduler: top level, stream ports, tick scale register
// depends on tts_pkg, tts_front, tts_cmd_fifo, tts_back
//
// One request is worked at a time by the back sequencer; the front and a
// two-entry queue keep accepting up to three more. Schedule or cancel scans
// the slots until a match or the last slot; multi-mode schedule binds with
// no scan; process scans every slot, with one result per due slot; complete
// works on the named slot, and a fixed-rate period step that must catch up
// runs a bit-serial remainder loop over the 63-bit time difference. Any
// output stall adds to the time a request takes. The scan speed is set by
// the slot table's single registered read port. A slot's free/occupied bit
// lives in flip-flops cleared by reset, so no clearing pass is needed.
module task_timer_scheduler import tts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // opcode, task_id, mode, rate_ms, now, slot, delay_ms, zero pad
  input  logic [IN_W-1:0]   s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // result_slot, due_task, wake_time, zero pad
  output logic [OUT_W-1:0]  m_axis_tdata_o,
  // result_kind
  output logic [2:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TPM_W-1:0]  cfg_data_i
);

  logic [TPM_W-1:0] tpm_q;
  item_t            item;
  logic             f_vld, f_rdy, b_vld, b_rdy;
  cmd_t             f_cmd, b_cmd;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= TPM_W'(1);
    end else if (cfg_valid_i) begin
      tpm_q <= cfg_data_i;
    end
  end

  always_comb begin
    item.opcode   = s_axis_tdata_i[1:0];
    item.task_id  = s_axis_tdata_i[17:2];
    item.mode     = s_axis_tdata_i[19:18];
    item.rate_ms  = s_axis_tdata_i[51:20];
    item.now      = s_axis_tdata_i[114:52];
    item.slot     = s_axis_tdata_i[118:115];
    item.delay_ms = s_axis_tdata_i[150:119];
  end

  tts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tpm_i       (tpm_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (item),
    .cmd_valid_o (f_vld),
    .cmd_ready_i (f_rdy),
    .cmd_o       (f_cmd)
  );

  tts_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_vld),
    .push_ready_o (f_rdy),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_vld),
    .pop_ready_i  (b_rdy),
    .pop_data_o   (b_cmd)
  );

  tts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tpm_i       (tpm_q),
    .cmd_valid_i (b_vld),
    .cmd_ready_o (b_rdy),
    .cmd_i       (b_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b0, res.wake, res.task_id, res.slot};
  assign m_axis_tuser_o = res.kind;

endmodule

FILE: tb/tts_checker.sv
`timescale 1ns / 1ps
// tts_checker: watches the request, result and tick-scale channels of the
// task timer scheduler, predicts every result and compares; depends on tts_pkg
module tts_checker import tts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             s_ready_i,
  input  logic [IN_W-1:0]  s_data_i,
  input  logic             m_valid_i,
  input  logic             m_ready_i,
  input  logic [OUT_W-1:0] m_data_i,
  input  logic [2:0]       m_user_i,
  input  logic             m_last_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [TPM_W-1:0] cfg_data_i,
  output int               pending_o,
  output int               fails_o
);

  typedef struct {
    kind_e              kind;
    logic [FSLOT_W-1:0] slot;
    logic [TASK_W-1:0]  task_id;
    logic [TIME_W-1:0]  wake;
    logic               last;
  } outcome_t;

  outcome_t          awaited_results[$];
  logic [TPM_W-1:0]  tick_scale;
  logic [TASK_W-1:0] tbl_task [SLOTS];
  logic [MODE_W-1:0] tbl_mode [SLOTS];
  logic [MS_W-1:0]   tbl_rate [SLOTS];
  logic [TIME_W-1:0] tbl_due  [SLOTS];
  logic [TIME_W-1:0] tbl_start[SLOTS];
  int                fails;

  assign pending_o = awaited_results.size();
  assign fails_o   = fails;

  function automatic logic [TIME_W-1:0] clamp_add(logic [TIME_W-1:0] a, logic [63:0] b);
    logic [63:0] s;
    s = {1'b0, a} + b;
    return (s > {1'b0, TMAX}) ? TMAX : s[TIME_W-1:0];
  endfunction

  // opcode sits in the lowest bits of the stream word
  function automatic item_t unpack_item(logic [IN_W-1:0] d);
    item_t it;
    it.opcode   = d[1:0];
    it.task_id  = d[17:2];
    it.mode     = d[19:18];
    it.rate_ms  = d[51:20];
    it.now      = d[114:52];
    it.slot     = d[118:115];
    it.delay_ms = d[150:119];
    return it;
  endfunction

  function automatic void push_result(kind_e k, int s, logic [TASK_W-1:0] id,
                                      logic [TIME_W-1:0] w, logic l);
    outcome_t o;
    o.kind = k; o.slot = s[FSLOT_W-1:0]; o.task_id = id; o.wake = w; o.last = l;
    awaited_results.push_back(o);
  endfunction

  function automatic void clear_slot(int i);
    tbl_task[i] = '0; tbl_mode[i] = '0; tbl_rate[i] = '0;
    tbl_due[i] = '0; tbl_start[i] = '0;
  endfunction

  function automatic void predict_request(item_t it);
    int                hit;
    logic              any;
    logic [TIME_W-1:0] wake, nx;
    logic [63:0]       period, k, big;
    logic [TASK_W-1:0] id;
    hit = -1;
    any = 1'b0;
    wake = TMAX;
    case (op_e'(it.opcode))
      OP_SCHED: begin
        if (it.task_id == '0) begin
          push_result(KIND_MISS, 0, '0, '0, 1'b1);
          return;
        end
        if (it.mode != MODE_MULTI)
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_task[i] == it.task_id) hit = i;
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_task[i] == '0) hit = i;
        if (hit < 0) begin
          push_result(KIND_MISS, 0, '0, '0, 1'b1);
          return;
        end
        nx = clamp_add(it.now, 64'(it.rate_ms) * 64'(tick_scale));
        tbl_task[hit] = it.task_id; tbl_mode[hit] = it.mode; tbl_rate[hit] = it.rate_ms;
        tbl_due[hit] = nx; tbl_start[hit] = nx;
        push_result(KIND_OK, hit, it.task_id, nx, 1'b1);
      end
      OP_CANCEL: begin
        if (it.task_id != '0)
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_task[i] == it.task_id) hit = i;
        if (hit < 0) begin
          push_result(KIND_MISS, 0, '0, '0, 1'b1);
        end else begin
          clear_slot(hit);
          push_result(KIND_OK, hit, it.task_id, '0, 1'b1);
        end
      end
      OP_PROCESS: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_task[i] != '0) begin
            if (tbl_due[i] <= it.now) push_result(KIND_DUE, i, tbl_task[i], tbl_due[i], 1'b0);
            if (!any || tbl_due[i] < wake) wake = tbl_due[i];
            any = 1'b1;
          end
        end
        if (any) push_result(KIND_WAKE, 0, '0, wake, 1'b1);
        else push_result(KIND_NONE, 0, '0, '0, 1'b1);
      end
      default: begin
        if (tbl_task[it.slot] == '0) begin
          push_result(KIND_MISS, 0, '0, '0, 1'b1);
          return;
        end
        id = tbl_task[it.slot];
        if (it.delay_ms != '0) begin
          nx = clamp_add(it.now, 64'(it.delay_ms) * 64'(tick_scale));
          tbl_due[it.slot] = nx;
          push_result(KIND_OK, it.slot, id, nx, 1'b1);
          return;
        end
        period = 64'(tbl_rate[it.slot]) * 64'(tick_scale);
        if (tbl_mode[it.slot] == MODE_FIXED && period != '0) begin
          // catch up by whole periods so the next run lies after now
          nx = clamp_add(tbl_start[it.slot], period);
          if (nx <= it.now) begin
            k = (64'(it.now) - 64'(nx)) / period + 64'd1;
            big = 64'(nx) + k * period;
            nx = (big > {1'b0, TMAX}) ? TMAX : big[TIME_W-1:0];
          end
          tbl_due[it.slot] = nx;
          tbl_start[it.slot] = nx;
          push_result(KIND_OK, it.slot, id, nx, 1'b1);
          return;
        end
        clear_slot(it.slot);
        push_result(KIND_OK, it.slot, id, '0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_r;
    if (!rst_ni) begin
      tick_scale <= 16'd1;
      for (int i = 0; i < SLOTS; i++) clear_slot(i);
      awaited_results.delete();
      fails <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (awaited_results.size() == 0) begin
          if (fails < 10)
            $display("%0t: result with nothing awaited: kind %0d slot %0d task %0d wake %0d",
                     $realtime, m_user_i, m_data_i[3:0], m_data_i[19:4], m_data_i[82:20]);
          fails <= fails + 1;
        end else begin
          exp_r = awaited_results.pop_front();
          if (m_user_i !== exp_r.kind || m_data_i[3:0] !== exp_r.slot ||
              m_data_i[19:4] !== exp_r.task_id || m_data_i[82:20] !== exp_r.wake ||
              m_data_i[87:83] !== '0 || m_last_i !== exp_r.last) begin
            if (fails < 10)
              $display("%0t: mismatch exp kind %0d slot %0d task %0d wake %0d last %0d, got kind %0d slot %0d task %0d wake %0d last %0d",
                       $realtime, exp_r.kind, exp_r.slot, exp_r.task_id, exp_r.wake, exp_r.last,
                       m_user_i, m_data_i[3:0], m_data_i[19:4], m_data_i[82:20], m_last_i);
            fails <= fails + 1;
          end
        end
      end
      if (s_valid_i && s_ready_i) predict_request(unpack_item(s_data_i));
      if (cfg_valid_i && cfg_ready_i) tick_scale <= cfg_data_i;
    end
  end

endmodule

FILE: tb/tb_task_timer_scheduler.sv
`timescale 1ns / 1ps
// tb_task_timer_scheduler: drives requests, tick-scale writes and result
// stalls into the scheduler and gives the verdict; depends on tts_pkg, tts_checker, task_timer_scheduler
module tb_task_timer_scheduler;
  import tts_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;
  logic [2:0]        m_axis_tuser_o;
  logic              m_axis_tlast_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [TPM_W-1:0]  cfg_data_i = '0;
  int                pending, fails;
  logic              quiet = 1'b0;
  logic              hold_req = 1'b0;
  logic [TIME_W-1:0] sim_now = '0;
  logic [TPM_W-1:0]  scale = 16'd1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task_timer_scheduler DUT (.*);

  tts_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid_i), .s_ready_i(s_axis_tready_o), .s_data_i(s_axis_tdata_i),
    .m_valid_i(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i), .m_data_i(m_axis_tdata_o),
    .m_user_i(m_axis_tuser_o), .m_last_i(m_axis_tlast_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .pending_o(pending), .fails_o(fails)
  );

  task automatic offer_request(op_e op, logic [TASK_W-1:0] id, logic [MODE_W-1:0] md,
                               logic [MS_W-1:0] rate, logic [TIME_W-1:0] now_t,
                               logic [FSLOT_W-1:0] sl, logic [MS_W-1:0] dly);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, dly, sl, now_t, rate, md, id, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic set_tick_scale(logic [TPM_W-1:0] v);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scale = v;
  endtask

  task automatic random_request();
    int                r;
    op_e               op;
    logic [TASK_W-1:0] id;
    logic [MS_W-1:0]   rate, dly;
    r = $urandom_range(0, 99);
    op = (r < 35) ? OP_SCHED : (r < 50) ? OP_CANCEL : (r < 70) ? OP_PROCESS : OP_COMPLETE;
    r = $urandom_range(0, 99);
    id = (r < 4) ? '0 : (r < 9) ? TASK_W'($urandom) : TASK_W'($urandom_range(1, 24));
    rate = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 40);
    r = $urandom_range(0, 9);
    dly = (r < 4) ? '0 : (r < 9) ? $urandom_range(1, 40) : $urandom;
    r = $urandom_range(0, 99);
    if (r < 3) sim_now = {$urandom, $urandom};
    else if (r < 5) sim_now = TMAX - $urandom_range(0, 100);
    else sim_now = sim_now + 63'($urandom_range(0, 60)) * scale;
    offer_request(op, id, MODE_W'($urandom_range(0, 3)), rate, sim_now,
                  FSLOT_W'($urandom_range(0, 15)), dly);
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (quiet) begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, rejects, rebind, multi, fixed rate, mode 3
    offer_request(OP_PROCESS, 0, 0, 0, 0, 0, 0);
    offer_request(OP_SCHED, 0, 0, 10, 0, 0, 0);
    offer_request(OP_SCHED, 1, 0, 10, 0, 0, 0);
    offer_request(OP_SCHED, 1, 0, 20, 0, 0, 0);
    offer_request(OP_SCHED, 2, MODE_MULTI, 5, 0, 0, 0);
    offer_request(OP_SCHED, 2, MODE_MULTI, 5, 0, 0, 0);
    offer_request(OP_SCHED, 3, MODE_FIXED, 7, 0, 0, 0);
    offer_request(OP_SCHED, 4, 2'd3, 0, 0, 0, 0);
    offer_request(OP_CANCEL, 0, 0, 0, 0, 0, 0);
    offer_request(OP_CANCEL, 999, 0, 0, 0, 0, 0);
    offer_request(OP_CANCEL, 2, 0, 0, 0, 0, 0);
    offer_request(OP_PROCESS, 0, 0, 0, 8, 0, 0);
    offer_request(OP_COMPLETE, 0, 0, 0, 8, 1, 0);
    offer_request(OP_COMPLETE, 0, 0, 0, 8, 15, 5);
    offer_request(OP_COMPLETE, 0, 0, 0, 8, 0, 5);
    offer_request(OP_COMPLETE, 0, 0, 0, 100, 3, 0);
    offer_request(OP_COMPLETE, 0, 0, 0, 100, 4, 0);
    // zero-period fixed rate task frees on completion
    offer_request(OP_SCHED, 5, MODE_FIXED, 0, 100, 0, 0);
    offer_request(OP_COMPLETE, 0, 0, 0, 100, 1, 0);
    // saturation near the top of time
    offer_request(OP_SCHED, 6, MODE_FIXED, '1, TMAX - 3, 0, 0);
    offer_request(OP_COMPLETE, 0, 0, 0, TMAX, 1, '1);
    offer_request(OP_PROCESS, 16'hFFFF, 0, 0, TMAX, 0, 0);
    // fill the table until schedule runs out of slots, then process the full table
    for (int i = 0; i < 16; i++)
      offer_request(OP_SCHED, TASK_W'(9 + i), MODE_MULTI, MS_W'(i), 50, 0, 0);
    offer_request(OP_PROCESS, 0, 0, 0, 60, 0, 0);
    sim_now = 60;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_tick_scale(16'hFFFF);
        1: set_tick_scale(16'd1);
        2: set_tick_scale(16'd7);
        default: set_tick_scale(TPM_W'($urandom_range(1, 65535)));
      endcase
      quiet = (ph == 3);
      for (int n = 0; n < 98; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        random_request();
      end
    end
    set_tick_scale(16'd1);

    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
